/* sv/lora_time_on_air_macros.svh */
// Assertion macros for the LoRa time-on-air block.
// Used by the top level only; compiled out when SYNTHESIS is defined.
`ifndef LORA_TIME_ON_AIR_MACROS_SVH
`define LORA_TIME_ON_AIR_MACROS_SVH
`ifndef SYNTHESIS
// Plain property check, clocked and disabled in reset.
`define LOT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Overlapping implication check.
`define LOT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define LOT_ASSERT(lbl, clk, rstn, prop, msg)
`define LOT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* sv/lot_pkg.sv */
// Shared types, widths, constants and lookup functions for the time-on-air block.
// No dependencies.
`default_nettype none

package lot_pkg;

  // port widths
  localparam int unsigned PAY_W      = 8;
  localparam int unsigned SF_W       = 4;
  localparam int unsigned BWC_W      = 4;
  localparam int unsigned PRE_W      = 16;
  localparam int unsigned OUT_W      = 36;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // spreading factor handling
  localparam int unsigned SF_MIN       = 5;
  localparam int unsigned SF_MAX       = 12;
  localparam int unsigned SF_LONG_MIN  = 7;   // long header variant from here on
  localparam int unsigned LONG_EXTRA   = 8;   // extra numerator bits, long variant
  localparam int unsigned LDRO_RATIO   = 17;  // ldro when 2^sf >= 17 * bw_khz
  localparam int unsigned LDRO_SF_DROP = 2;
  localparam int unsigned QTR_LONG     = 33;  // 8.25 symbols in quarters
  localparam int unsigned QTR_SHORT    = 41;  // 10.25 symbols in quarters

  // datapath widths (sized for CRC_BITS <= 32, HEADER_TERM <= 64)
  localparam int unsigned NUM_W        = 12;
  localparam int unsigned M_W          = NUM_W - 2;
  localparam int unsigned RCP_W        = 16;
  localparam int unsigned RCP_SHIFT    = 16;
  localparam int unsigned PROD_W       = M_W + RCP_W;
  localparam int unsigned SYM_W        = PROD_W - RCP_SHIFT;
  localparam int unsigned Q_W          = 20;
  localparam int unsigned KHZ_W        = 9;
  localparam int unsigned NB_W         = 12;
  localparam int unsigned DB_W         = 9;
  localparam int unsigned P_W          = Q_W + NB_W;
  localparam int unsigned LDRO_W       = 14;

  // pipeline shape
  localparam int unsigned FRONT_STAGES = 5;
  localparam int unsigned DIV_STEP     = 3;
  localparam int unsigned DIV_STAGES   = 15;
  localparam int unsigned X_W          = DIV_STEP * DIV_STAGES;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONLINE = 2'd0,
    CFG_SF     = 2'd1,
    CFG_BW     = 2'd2,
    CFG_PRE    = 2'd3
  } cfg_reg_e;

  // bandwidth codes
  localparam logic [BWC_W-1:0] BW_7K8   = 4'd0;
  localparam logic [BWC_W-1:0] BW_15K6  = 4'd1;
  localparam logic [BWC_W-1:0] BW_31K25 = 4'd2;
  localparam logic [BWC_W-1:0] BW_62K5  = 4'd3;
  localparam logic [BWC_W-1:0] BW_125K  = 4'd4;
  localparam logic [BWC_W-1:0] BW_250K  = 4'd5;
  localparam logic [BWC_W-1:0] BW_500K  = 4'd6;
  localparam logic [BWC_W-1:0] BW_10K4  = 4'd8;
  localparam logic [BWC_W-1:0] BW_20K8  = 4'd9;
  localparam logic [BWC_W-1:0] BW_41K7  = 4'd10;

  // reset values
  localparam logic                 RST_ONLINE = 1'b0;
  localparam logic [SF_W-1:0]      RST_SF     = 4'd7;
  localparam logic [BWC_W-1:0]     RST_BW     = BW_125K;
  localparam logic [PRE_W-1:0]     RST_PRE    = 16'd8;

  // decoded configuration; the user must keep it stable while items are in flight, the block does not enforce it
  typedef struct packed {
    logic              active;    // online and a valid bandwidth
    logic [SF_W-1:0]   sf;        // clamped to 5..12
    logic              sf_long;   // sf >= 7
    logic [SF_W-1:0]   den;       // sf, less 2 with ldro
    logic [RCP_W-1:0]  rcp;       // ceil(2^16 / den)
    logic [NB_W-1:0]   nb;        // 250000 / bw = nb / db, reduced
    logic [DB_W-1:0]   db;
    logic [PRE_W-1:0]  preamble;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [KHZ_W-1:0] khz;
    logic [NB_W-1:0]  nb;
    logic [DB_W-1:0]  db;
  } bw_info_t;

  // divider stage state: dividend/quotient shift word and partial remainder
  typedef struct packed {
    logic [X_W-1:0]  x;
    logic [DB_W-1:0] r;
  } div_t;

  function automatic bw_info_t bw_info(logic [BWC_W-1:0] code);
    bw_info_t res;
    case (code)
      BW_7K8:   res = '{1'b1, 9'd7,   12'd1250, 9'd39};
      BW_15K6:  res = '{1'b1, 9'd15,  12'd625,  9'd39};
      BW_31K25: res = '{1'b1, 9'd31,  12'd8,    9'd1};
      BW_62K5:  res = '{1'b1, 9'd62,  12'd4,    9'd1};
      BW_125K:  res = '{1'b1, 9'd125, 12'd2,    9'd1};
      BW_250K:  res = '{1'b1, 9'd250, 12'd1,    9'd1};
      BW_500K:  res = '{1'b1, 9'd500, 12'd1,    9'd2};
      BW_10K4:  res = '{1'b1, 9'd10,  12'd625,  9'd26};
      BW_20K8:  res = '{1'b1, 9'd20,  12'd625,  9'd52};
      BW_41K7:  res = '{1'b1, 9'd41,  12'd2500, 9'd417};
      default:  res = '{1'b0, 9'd0,   12'd0,    9'd1};
    endcase
    return res;
  endfunction

  // ceil(2^16 / d); exact floor(m / d) for m < 1024 after >> 16
  function automatic logic [RCP_W-1:0] recip(logic [SF_W-1:0] d);
    logic [RCP_W-1:0] res;
    case (d)
      4'd5:    res = 16'd13108;
      4'd6:    res = 16'd10923;
      4'd7:    res = 16'd9363;
      4'd8:    res = 16'd8192;
      4'd9:    res = 16'd7282;
      4'd10:   res = 16'd6554;
      4'd11:   res = 16'd5958;
      4'd12:   res = 16'd5462;
      default: res = 16'd0;
    endcase
    return res;
  endfunction

  // DIV_STEP restoring steps; quotient bits shift in at the bottom of x
  function automatic div_t div_steps(div_t in, logic [DB_W-1:0] d);
    div_t         res;
    logic [DB_W:0] t;
    res = in;
    for (int i = 0; i < DIV_STEP; i++) begin
      t     = {res.r, res.x[X_W-1]};
      res.x = {res.x[X_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        res.r    = DB_W'(t - {1'b0, d});
        res.x[0] = 1'b1;
      end else begin
        res.r = t[DB_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/lot_cfg.sv */
// Configuration registers and their decode into lot_pkg::cfg_t.
// Depends on lot_pkg.
`default_nettype none

module lot_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lot_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lot_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output lot_pkg::cfg_t                    cfg_o
);

  logic                            radio_online_q;
  logic [lot_pkg::SF_W-1:0]        spreading_factor_q;
  logic [lot_pkg::BWC_W-1:0]       bandwidth_code_q;
  logic [lot_pkg::PRE_W-1:0]       preamble_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radio_online_q     <= lot_pkg::RST_ONLINE;
      spreading_factor_q <= lot_pkg::RST_SF;
      bandwidth_code_q   <= lot_pkg::RST_BW;
      preamble_length_q  <= lot_pkg::RST_PRE;
    end else if (cfg_we_i) begin
      case (lot_pkg::cfg_reg_e'(cfg_index_i))
        lot_pkg::CFG_ONLINE: radio_online_q     <= cfg_data_i[0];
        lot_pkg::CFG_SF:     spreading_factor_q <= cfg_data_i[lot_pkg::SF_W-1:0];
        lot_pkg::CFG_BW:     bandwidth_code_q   <= cfg_data_i[lot_pkg::BWC_W-1:0];
        lot_pkg::CFG_PRE:    preamble_length_q  <= cfg_data_i[lot_pkg::PRE_W-1:0];
        default: ;
      endcase
    end
  end

  lot_pkg::bw_info_t             bw;
  logic [lot_pkg::SF_W-1:0]      sf_c;
  logic [lot_pkg::LDRO_W-1:0]    two_sf;
  logic [lot_pkg::LDRO_W-1:0]    ldro_thr;
  logic                          sf_long;
  logic                          ldro;
  logic [lot_pkg::SF_W-1:0]      den;

  always_comb begin
    bw = lot_pkg::bw_info(bandwidth_code_q);
    if (spreading_factor_q < lot_pkg::SF_W'(lot_pkg::SF_MIN)) begin
      sf_c = lot_pkg::SF_W'(lot_pkg::SF_MIN);
    end else if (spreading_factor_q > lot_pkg::SF_W'(lot_pkg::SF_MAX)) begin
      sf_c = lot_pkg::SF_W'(lot_pkg::SF_MAX);
    end else begin
      sf_c = spreading_factor_q;
    end
    sf_long  = sf_c >= lot_pkg::SF_W'(lot_pkg::SF_LONG_MIN);
    // floor(2^sf / khz) > 16  <=>  2^sf >= 17 * khz
    two_sf   = lot_pkg::LDRO_W'(1) << sf_c;
    ldro_thr = lot_pkg::LDRO_W'(bw.khz) * lot_pkg::LDRO_W'(lot_pkg::LDRO_RATIO);
    ldro     = sf_long && (two_sf >= ldro_thr);
    den      = ldro ? sf_c - lot_pkg::SF_W'(lot_pkg::LDRO_SF_DROP) : sf_c;

    cfg_o.active   = radio_online_q && bw.valid;
    cfg_o.sf       = sf_c;
    cfg_o.sf_long  = sf_long;
    cfg_o.den      = den;
    cfg_o.rcp      = lot_pkg::recip(den);
    cfg_o.nb       = bw.nb;
    cfg_o.db       = bw.db;
    cfg_o.preamble = preamble_length_q;
  end

endmodule

`default_nettype wire

/* sv/lot_front.sv */
// Front pipeline: symbol count, quarter-symbol total and scaled dividend.
// Five register stages; depends on lot_pkg.
`default_nettype none

module lot_front #(
  parameter int unsigned CRC_BITS    = 16,
  parameter int unsigned HEADER_TERM = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lot_pkg::cfg_t                cfg_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [lot_pkg::PAY_W-1:0]    payload_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [lot_pkg::X_W-1:0]      x_o
);

  localparam int unsigned NS = lot_pkg::FRONT_STAGES;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  assign rdy[NS] = ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: ceil numerator, clamped, pre-divided by 4
  logic [lot_pkg::NUM_W-1:0]  num_pos;
  logic [lot_pkg::NUM_W-1:0]  num_sub;
  logic [lot_pkg::NUM_W-1:0]  num_ceil;
  logic [lot_pkg::M_W-1:0]    m_d, m_q;

  always_comb begin
    num_pos = lot_pkg::NUM_W'({payload_i, 3'b000}) + lot_pkg::NUM_W'(CRC_BITS)
            + lot_pkg::NUM_W'(HEADER_TERM)
            + (cfg_i.sf_long ? lot_pkg::NUM_W'(lot_pkg::LONG_EXTRA) : '0);
    num_sub = lot_pkg::NUM_W'({cfg_i.sf, 2'b00});
    num_ceil = num_pos - num_sub + lot_pkg::NUM_W'({cfg_i.den, 2'b00})
             - lot_pkg::NUM_W'(1);
    m_d = (num_pos > num_sub) ? num_ceil[lot_pkg::NUM_W-1:2] : '0;
  end

  // stage 1: payload symbols = floor(m / den) by reciprocal
  logic [lot_pkg::PROD_W-1:0] sym_prod;
  logic [lot_pkg::SYM_W-1:0]  syms_q;

  assign sym_prod = lot_pkg::PROD_W'(m_q) * lot_pkg::PROD_W'(cfg_i.rcp);

  // stage 2: total in quarter symbols
  logic [lot_pkg::Q_W-3:0]    sym_sum;
  logic [lot_pkg::Q_W-1:0]    qtr_d, qtr_q;

  always_comb begin
    sym_sum = (lot_pkg::Q_W-2)'(syms_q) + (lot_pkg::Q_W-2)'(cfg_i.preamble);
    qtr_d   = {sym_sum, 2'b00}
            + (cfg_i.sf_long ? lot_pkg::Q_W'(lot_pkg::QTR_LONG)
                             : lot_pkg::Q_W'(lot_pkg::QTR_SHORT));
  end

  // stage 3: scale by the bandwidth numerator
  logic [lot_pkg::P_W-1:0]    p_d, p_q;
  assign p_d = lot_pkg::P_W'(qtr_q) * lot_pkg::P_W'(cfg_i.nb);

  // stage 4: times 2^sf; zero dividend when offline or bandwidth unused
  logic [lot_pkg::X_W-1:0]    x_d, x_q;
  assign x_d = cfg_i.active ? (lot_pkg::X_W'(p_q) << cfg_i.sf) : '0;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) m_q    <= m_d;
    if (rdy[1]) syms_q <= sym_prod[lot_pkg::PROD_W-1:lot_pkg::RCP_SHIFT];
    if (rdy[2]) qtr_q  <= qtr_d;
    if (rdy[3]) p_q    <= p_d;
    if (rdy[4]) x_q    <= x_d;
  end

  assign x_o = x_q;

endmodule

`default_nettype wire

/* sv/lot_div.sv */
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
// Depends on lot_pkg.
`default_nettype none

module lot_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lot_pkg::DB_W-1:0]     divisor_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [lot_pkg::X_W-1:0]      x_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [lot_pkg::X_W-1:0]      quot_o
);

  localparam int unsigned NS = lot_pkg::DIV_STAGES;

  logic [NS-1:0]  v_q;
  logic [NS:0]    rdy;
  lot_pkg::div_t  st_q [NS];
  lot_pkg::div_t  st_d [NS];
  lot_pkg::div_t  head;

  assign rdy[NS] = ready_i;
  assign head    = '{x: x_i, r: '0};

  for (genvar k = 0; k < NS; k++) begin : g_stage
    assign rdy[k] = !v_q[k] || rdy[k+1];
    if (k == 0) begin : g_first
      assign st_d[k] = lot_pkg::div_steps(head, divisor_i);
    end else begin : g_next
      assign st_d[k] = lot_pkg::div_steps(st_q[k-1], divisor_i);
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) st_q[k] <= st_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NS-1];
  assign quot_o  = st_q[NS-1].x;

endmodule

`default_nettype wire

/* sv/lora_time_on_air.sv */
// LoRa time on air: payload length in, airtime in whole microseconds out.
// Pipeline: 5 front stages plus 15 divider stages, 3 quotient bits each.
// Throughput one beat per cycle while the output is not stalled; a stall holds only the stages that are full.
// Reset (async, active low) empties the pipe and loads the register defaults.
// Uses lot_pkg, lot_cfg, lot_front, lot_div and lora_time_on_air_macros.svh.
`default_nettype none
`include "lora_time_on_air_macros.svh"

module lora_time_on_air #(
  parameter int unsigned CRC_BITS    = 16,
  parameter int unsigned HEADER_TERM = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lot_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lot_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // payload length in
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lot_pkg::PAY_W-1:0]         payload_length_i,
  // airtime out
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lot_pkg::OUT_W-1:0]         airtime_us_o
);

  // The math, all exact integer work:
  //   Q     = 4 * (ceil(max(0,num) / (4 * den)) + preamble) + 33 or 41 quarter symbols
  //   t_us  = floor(Q * 2^sf * 250000 / bw)
  // 250000 / bw is kept as a reduced fraction nb / db from a table, so the
  // final step is a 45-bit dividend over a divisor of at most 417. The small
  // symbol division uses a reciprocal table (den is only 5..12).

  // Config regs are always writable; writes are expected only while idle.
  assign cfg_ready_o = 1'b1;

  lot_pkg::cfg_t cfg;

  lot_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Front: numerator/ceil, symbol divide, quarter total, nb scale, 2^sf shift.
  logic                      front_ready;
  logic                      front_valid;
  logic                      div_ready;
  logic [lot_pkg::X_W-1:0]   front_x;

  lot_front #(
    .CRC_BITS    (CRC_BITS),
    .HEADER_TERM (HEADER_TERM)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (in_valid_i),
    .ready_o   (front_ready),
    .payload_i (payload_length_i),
    .valid_o   (front_valid),
    .ready_i   (div_ready),
    .x_o       (front_x)
  );

  // Divide by db. Offline or unused bandwidth feeds a zero dividend,
  // which comes out as a zero airtime.
  logic [lot_pkg::X_W-1:0]   quot;

  lot_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .divisor_i (cfg.db),
    .valid_i   (front_valid),
    .ready_o   (div_ready),
    .x_i       (front_x),
    .valid_o   (out_valid_o),
    .ready_i   (!out_stall_i),
    .quot_o    (quot)
  );

  // Each stage advances when it is empty or the next one moves, so bubbles
  // fill in behind a stalled output and the last stage doubles as the
  // output register.
  assign in_stall_o   = !front_ready;
  assign airtime_us_o = quot[lot_pkg::OUT_W-1:0];

  // Occupancy, checks only.
  localparam int unsigned TOTAL = lot_pkg::FRONT_STAGES + lot_pkg::DIV_STAGES;
  localparam int unsigned OCC_W = $clog2(TOTAL + 1);

  logic             in_beat;
  logic             out_beat;
  logic [OCC_W-1:0] occ_d, occ_q;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;
  assign occ_d    = occ_q + OCC_W'(in_beat) - OCC_W'(out_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `LOT_ASSERT(a_occ_bound, clk_i, rst_ni, (occ_q <= OCC_W'(TOTAL)), "pipe holds too many beats")
  `LOT_ASSERT_IMPL(a_empty_idle, clk_i, rst_ni, (occ_q == '0), !out_valid_o, "result from empty pipe")
  `LOT_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, (out_valid_o && out_stall_i), "input stalled without output stall")
  `LOT_ASSERT_IMPL(a_full_stall, clk_i, rst_ni, ((occ_q == OCC_W'(TOTAL)) && out_stall_i), in_stall_o, "input taken into full pipe")

endmodule

`default_nettype wire
